>>> src/pttt_pkg.sv
// Package for the periodic task timer table: request and result structs,
// request codes, task states, sequencer states, register addresses and the max_interval reset value. No dependencies.
`default_nettype none
package pttt_pkg;

    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_ADD     = 3'd1,
        REQ_PAUSE   = 3'd2,
        REQ_RESTART = 3'd3,
        REQ_MODIFY  = 3'd4,
        REQ_REMOVE  = 3'd5,
        REQ_QUERY   = 3'd6,
        REQ_BAD     = 3'd7
    } t_req;

    localparam logic [1:0] ST_PAUSED   = 2'd0;
    localparam logic [1:0] ST_PERIODIC = 2'd1;
    localparam logic [1:0] ST_ONESHOT  = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    localparam logic [31:0] MAX_IVL_RESET = 32'd225000;

    localparam logic [0:0] ADDR_ENABLE = 1'b0;
    localparam logic [0:0] ADDR_MAXIVL = 1'b1;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [15:0] task_key;
        logic [31:0] interval;
        logic [2:0]  mode;
    } t_in;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_key_res;
        logic        code;
        logic [1:0]  task_state;
        logic        last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND,
        S_TICK_RD,
        S_TICK_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_APPLY,
        S_REPLY,
        S_EMIT,
        S_WAIT
    } t_state;

endpackage
`default_nettype wire

>>> src/periodic_task_timer_table.sv
// Top level of the periodic task timer table: configuration registers
// and the APB port, around pttt_ctrl. Depends on pttt_pkg and pttt_ctrl.
//
// Usage: a request carries req_type, task_key, interval and mode on the
// input channel (valid/ready). Management requests (add, pause, restart,
// modify, remove, query) give exactly one reply with last set. A tick request
// advances the 32-bit tick counter and gives one result per task that is due,
// the final one marked last; a tick with nothing due gives no result.
// A management request walks the key search and, for remove, the compaction
// that copies each later entry down one slot in a read and a write step. A
// tick visits each entry in a read and a check step, and moves the later
// entries down one slot when a one-shot task leaves. Ready is high only
// while the sequencer is idle, one item at a time.
// Results sit in an output register; when the receiver stalls and a result
// waits to be loaded, the sequencer holds its walk until the register frees.
// Reset (synchronous, active low) clears the tick counter, the entry count,
// enable and max_interval (225000); the entry memory is not cleared and
// needs no clearing pass, since only entries below the count are read.
// Registers: enable at byte address 0, max_interval at byte address 4.
`default_nettype none
module periodic_task_timer_table #(
    parameter int MAX_ENTRIES = 10
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  wire  pttt_pkg::t_in  i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output pttt_pkg::t_out       o_out_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [2:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic        r_enable;
    logic [31:0] r_max_ivl;

    assign pready = 1'b1;

    // Register writes at the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_max_ivl <= pttt_pkg::MAX_IVL_RESET;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == pttt_pkg::ADDR_ENABLE && paddr[1:0] == 2'd0)
                r_enable <= pwdata[0];
            else if (paddr[2] == pttt_pkg::ADDR_MAXIVL && paddr[1:0] == 2'd0)
                r_max_ivl <= pwdata;
        end
    end

    always_comb begin
        if (paddr[2] == pttt_pkg::ADDR_ENABLE) prdata = {31'd0, r_enable};
        else prdata = r_max_ivl;
    end

    pttt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_enable       (r_enable),
        .i_max_interval (r_max_ivl),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in           (i_in_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out          (o_out_data)
    );
endmodule
`default_nettype wire

>>> src/pttt_ctrl.sv
// Sequencer and shared datapath of the periodic task timer table.
// Depends on pttt_pkg. Holds the entry memory and walks it one entry at a time.
`default_nettype none
module pttt_ctrl #(
    parameter int MAX_ENTRIES = 10
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_enable,
    input  wire  [31:0]         i_max_interval,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  pttt_pkg::t_in i_in,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output pttt_pkg::t_out      o_out
);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // One entry: key, interval, due, state.
    logic [15:0] m_key [MAX_ENTRIES];
    logic [31:0] m_ivl [MAX_ENTRIES];
    logic [31:0] m_due [MAX_ENTRIES];
    logic [1:0]  m_st  [MAX_ENTRIES];

    pttt_pkg::t_state r_state, n_state;
    pttt_pkg::t_in    r_req;
    logic [31:0]      r_tick;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    r_idx;
    logic             r_found;
    logic [15:0]      r_key;
    logic [31:0]      r_ivl, r_due;
    logic [1:0]       r_st;
    pttt_pkg::t_out   r_out;
    logic             r_ovalid;
    logic             r_pend;       // a due result is buffered, not yet marked last
    pttt_pkg::t_out   r_hold;
    logic [CW-1:0]    r_shift_base; // entry count before the removal
    logic [CW-1:0]    r_gap;        // slot freed by the removal

    // Shared adder: tick + interval.
    logic [31:0] w_ivl_cl;
    logic [31:0] w_sum;
    logic [31:0] w_diff;
    logic        w_rd_last;
    logic [IW-1:0] w_a, w_a1;

    assign w_a  = r_idx[IW-1:0];
    assign w_a1 = IW'(r_idx + CW'(1));
    assign w_ivl_cl = (r_req.interval == 32'd0 || r_req.interval > i_max_interval)
                      ? 32'd1 : r_req.interval;
    assign w_diff = r_tick - r_due;
    assign w_rd_last = (r_idx + CW'(1) >= r_cnt);

    always_comb begin
        unique case (pttt_pkg::t_req'(r_req.req_type))
            pttt_pkg::REQ_ADD:
                w_sum = r_tick + (r_req.mode[2] ? 32'd0 : w_ivl_cl);
            pttt_pkg::REQ_MODIFY: w_sum = r_tick + w_ivl_cl;
            default:              w_sum = r_tick + r_ivl;
        endcase
    end

    // Reply fields of a management request.
    logic       w_ok;
    logic [1:0] w_qst;
    always_comb begin
        w_ok  = 1'b0;
        w_qst = pttt_pkg::ST_PAUSED;
        unique case (pttt_pkg::t_req'(r_req.req_type))
            pttt_pkg::REQ_ADD: w_ok = i_enable && (r_cnt < CW'(MAX_ENTRIES));
            pttt_pkg::REQ_PAUSE, pttt_pkg::REQ_RESTART, pttt_pkg::REQ_MODIFY,
            pttt_pkg::REQ_REMOVE: w_ok = r_found;
            pttt_pkg::REQ_QUERY: begin
                w_ok  = r_found;
                w_qst = r_found ? r_st : pttt_pkg::ST_NONE;
            end
            default: ;
        endcase
    end

    logic w_out_free;
    assign w_out_free = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == pttt_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

    logic w_due;
    assign w_due = (r_st != pttt_pkg::ST_PAUSED) && !w_diff[31];

    pttt_pkg::t_out w_hold_last;
    always_comb begin
        w_hold_last      = r_hold;
        w_hold_last.last = 1'b1;
    end

    // The output register is loaded only when it is free.
    logic w_out_load;
    always_comb begin
        unique case (r_state)
            pttt_pkg::S_TICK_CHK: w_out_load = w_due && r_pend && w_out_free;
            pttt_pkg::S_REPLY:    w_out_load = w_out_free;
            pttt_pkg::S_EMIT:     w_out_load = r_pend && w_out_free;
            default:              w_out_load = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pttt_pkg::S_IDLE:
                if (i_in_valid) begin
                    if (i_in.req_type == pttt_pkg::REQ_TICK) begin
                        n_state = pttt_pkg::S_TICK_RD;
                    end else begin
                        n_state = pttt_pkg::S_FIND;
                    end
                end
            pttt_pkg::S_FIND:
                if (r_found || r_idx >= r_cnt) n_state = pttt_pkg::S_APPLY;
            pttt_pkg::S_APPLY:
                if (r_req.req_type == pttt_pkg::REQ_REMOVE && r_found &&
                        r_idx + CW'(1) < r_cnt) begin
                    n_state = pttt_pkg::S_SHIFT_RD;
                end else begin
                    n_state = pttt_pkg::S_REPLY;
                end
            pttt_pkg::S_TICK_RD:
                if (r_idx >= r_cnt) n_state = pttt_pkg::S_EMIT;
                else n_state = pttt_pkg::S_TICK_CHK;
            pttt_pkg::S_TICK_CHK:
                if (w_due && !w_out_free && r_pend) n_state = pttt_pkg::S_TICK_CHK;
                else if (w_due && r_st == pttt_pkg::ST_ONESHOT && !w_rd_last)
                    n_state = pttt_pkg::S_SHIFT_RD;
                else n_state = pttt_pkg::S_TICK_RD;
            pttt_pkg::S_SHIFT_RD: n_state = pttt_pkg::S_SHIFT_WR;
            pttt_pkg::S_SHIFT_WR:
                if (r_idx + CW'(2) >= r_shift_base) begin
                    n_state = (r_req.req_type == pttt_pkg::REQ_TICK)
                              ? pttt_pkg::S_TICK_RD : pttt_pkg::S_REPLY;
                end else begin
                    n_state = pttt_pkg::S_SHIFT_RD;
                end
            pttt_pkg::S_REPLY:
                if (w_out_free) n_state = pttt_pkg::S_WAIT;
            pttt_pkg::S_EMIT:
                if (!r_pend || w_out_free) n_state = pttt_pkg::S_WAIT;
            pttt_pkg::S_WAIT: n_state = pttt_pkg::S_IDLE;
            default: n_state = pttt_pkg::S_IDLE;
        endcase
    end

    // Shift phase: r_idx is the slot written; the read comes from r_idx+1.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pttt_pkg::S_IDLE;
            r_tick     <= '0;
            r_cnt      <= '0;
            r_ovalid   <= 1'b0;
            r_pend     <= 1'b0;
            r_idx      <= '0;
            r_found    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                pttt_pkg::S_IDLE:
                    if (i_in_valid) begin
                        r_req   <= i_in;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_pend  <= 1'b0;
                        if (i_in.req_type == pttt_pkg::REQ_TICK) r_tick <= r_tick + 32'd1;
                    end
                pttt_pkg::S_FIND:
                    if (!r_found && r_idx < r_cnt) begin
                        if (i_enable && m_key[w_a] == r_req.task_key) begin
                            r_found <= 1'b1;
                            r_ivl   <= m_ivl[w_a];
                            r_st    <= m_st[w_a];
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                pttt_pkg::S_APPLY: begin
                    r_hold <= '{kind: 1'b0, task_key_res: r_req.task_key, code: !w_ok,
                                task_state: w_qst, last: 1'b1};
                    unique case (pttt_pkg::t_req'(r_req.req_type))
                        pttt_pkg::REQ_ADD:
                            if (w_ok) begin
                                m_key[r_cnt[IW-1:0]] <= r_req.task_key;
                                m_ivl[r_cnt[IW-1:0]] <= w_ivl_cl;
                                m_st[r_cnt[IW-1:0]]  <= (r_req.mode[1:0] == 2'd3)
                                    ? pttt_pkg::ST_PERIODIC : r_req.mode[1:0];
                                m_due[r_cnt[IW-1:0]] <= w_sum;
                                r_cnt <= r_cnt + CW'(1);
                            end
                        pttt_pkg::REQ_PAUSE:
                            if (r_found) m_st[w_a] <= pttt_pkg::ST_PAUSED;
                        pttt_pkg::REQ_RESTART:
                            if (r_found) begin
                                m_st[w_a]  <= pttt_pkg::ST_PERIODIC;
                                m_due[w_a] <= w_sum;
                            end
                        pttt_pkg::REQ_MODIFY:
                            if (r_found) begin
                                m_ivl[w_a] <= w_ivl_cl;
                                if (r_req.mode[1:0] == pttt_pkg::ST_PERIODIC ||
                                        r_req.mode[1:0] == pttt_pkg::ST_ONESHOT)
                                    m_st[w_a] <= r_req.mode[1:0];
                                m_due[w_a] <= w_sum;
                            end
                        pttt_pkg::REQ_REMOVE:
                            if (r_found) begin
                                r_cnt        <= r_cnt - CW'(1);
                                r_shift_base <= r_cnt;
                                r_gap        <= r_idx;
                            end
                        default: ;
                    endcase
                end
                pttt_pkg::S_TICK_RD:
                    if (r_idx < r_cnt) begin
                        r_key <= m_key[w_a];
                        r_ivl <= m_ivl[w_a];
                        r_due <= m_due[w_a];
                        r_st  <= m_st[w_a];
                    end
                pttt_pkg::S_TICK_CHK:
                    if (!(w_due && !w_out_free && r_pend)) begin
                        if (w_due) begin
                            // Release the previously buffered due result, buffer this one.
                            if (r_pend) r_out <= r_hold;
                            r_hold <= '{kind: 1'b1, task_key_res: r_key, code: 1'b0,
                                        task_state: pttt_pkg::ST_PAUSED, last: 1'b0};
                            r_pend <= 1'b1;
                            if (r_st == pttt_pkg::ST_ONESHOT) begin
                                r_shift_base <= r_cnt;
                                r_gap        <= r_idx;
                                r_cnt        <= r_cnt - CW'(1);
                            end else begin
                                m_due[w_a] <= w_sum;
                                r_idx <= r_idx + CW'(1);
                            end
                        end else begin
                            r_idx <= r_idx + CW'(1);
                        end
                    end
                pttt_pkg::S_SHIFT_RD: begin
                    r_key <= m_key[w_a1];
                    r_ivl <= m_ivl[w_a1];
                    r_due <= m_due[w_a1];
                    r_st  <= m_st[w_a1];
                end
                pttt_pkg::S_SHIFT_WR: begin
                    m_key[w_a] <= r_key;
                    m_ivl[w_a] <= r_ivl;
                    m_due[w_a] <= r_due;
                    m_st[w_a]  <= r_st;
                    if (r_idx + CW'(2) >= r_shift_base) begin
                        // Back to the freed slot: for a tick it holds a new entry now.
                        r_idx <= r_gap;
                    end else begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                pttt_pkg::S_REPLY:
                    if (w_out_free) r_out <= w_hold_last;
                pttt_pkg::S_EMIT:
                    if (r_pend && w_out_free) begin
                        r_out  <= w_hold_last;
                        r_pend <= 1'b0;
                    end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> src/pttt_checker.sv
// Port checker for the periodic task timer table, bound to the top level.
// Depends on pttt_pkg.
`default_nettype none
module pttt_assert (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_in_valid,
    input wire                 o_in_ready,
    input wire                 o_out_valid,
    input wire                 i_out_ready,
    input wire pttt_pkg::t_out o_out_data
);
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
    // Not ready right after taking a request.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");
    // Replies are always final.
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.kind |-> o_out_data.last)
        else $error("reply without last");
    // Due results carry code done and state zero.
    a_due_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind |->
            !o_out_data.code && o_out_data.task_state == pttt_pkg::ST_PAUSED)
        else $error("bad due result");
endmodule

bind periodic_task_timer_table pttt_assert u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
`default_nettype wire
